### src/hsv2rgb_pkg.sv
// Package for the HSV to RGB converter: payload word types, the hue sector
// code and the fixed constants of the conversion. It depends on nothing.
package hsv2rgb_pkg;

    // Default number of fraction bits of saturation and value.
    localparam int FRAC_BITS_DEF = 12;

    // Number of register stages between the input and the output word.
    localparam int PIPE_STAGES = 7;

    // Hue geometry and channel scale.
    localparam int HUE_FULL   = 360;
    localparam int HUE_SECTOR = 60;
    localparam int CHAN_MAX   = 255;

    // A bias that is a multiple of 360 moves every signed hue into 352..65887,
    // so the wrapped hue is simply the biased value modulo 360.
    localparam int HUE_BIAS = HUE_FULL * 92;

    // Reciprocal of 360: the quotient is exact or one too small.
    localparam int HUE_RECIP_SHIFT = 22;
    localparam int HUE_RECIP       = (1 << HUE_RECIP_SHIFT) / HUE_FULL;
    localparam int HUE_QUOT_W      = 8;

    // Reciprocal of 60 rounded up: exact for every dividend below 2^14.
    localparam int DIV60_SHIFT = 20;
    localparam int DIV60_RECIP = ((1 << DIV60_SHIFT) + HUE_SECTOR - 1) / HUE_SECTOR;
    localparam int DIV60_W     = 15;

    // Scaled channel value before the division by 60 (at most 255 * 60).
    localparam int SCALED_W = 14;

    // Hue sector, named after the color at its start.
    typedef enum logic [2:0] {
        SECT_RED     = 3'd0,
        SECT_YELLOW  = 3'd1,
        SECT_GREEN   = 3'd2,
        SECT_CYAN    = 3'd3,
        SECT_BLUE    = 3'd4,
        SECT_MAGENTA = 3'd5
    } sector_t;

    // Input word.
    typedef struct packed {
        logic signed [15:0] hue_deg;
        logic signed [15:0] saturation;
        logic signed [15:0] brightness;
    } hsv_word_t;

    // Output word.
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_word_t;

endpackage

### src/hsv_to_rgb_converter_top.sv
// Top level of the HSV to RGB converter: pipeline control, hue path and
// channel path. Depends on hsv2rgb_pkg and the three hsv2rgb_ modules.
//
//   Channel   Word        Handshake              Direction
//   hsv       hsv_word_t  hsv_valid / hsv_stall  in
//   rgb       rgb_word_t  rgb_valid / rgb_stall  out
//
// One word is taken per clock while hsv_stall is low. It passes through every
// register stage in order before it can leave as a result word.
// The stage count is set by the two reciprocal dividers and the chain of
// multipliers for q and t, each followed by a register.
// Reset clears only the valid bits; the payload registers are not reset.
// A stall holds the full stages, while empty stages before them keep filling.
module hsv_to_rgb_converter_top #(
    parameter int FRAC_BITS = hsv2rgb_pkg::FRAC_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   hsv_valid,
    output logic                   hsv_stall,
    input  hsv2rgb_pkg::hsv_word_t hsv,
    output logic                   rgb_valid,
    input  logic                   rgb_stall,
    output hsv2rgb_pkg::rgb_word_t rgb
);

    localparam int STAGES = hsv2rgb_pkg::PIPE_STAGES;

    logic [STAGES-1:0]    stage_load;
    hsv2rgb_pkg::sector_t sector;
    logic [5:0]           remainder;

    // Valid bits and load enables.
    hsv2rgb_pipe_ctrl #(
        .STAGES     (STAGES)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (hsv_valid),
        .in_stall   (hsv_stall),
        .out_valid  (rgb_valid),
        .out_stall  (rgb_stall),
        .stage_load (stage_load)
    );

    // Hue to sector and remainder.
    hsv2rgb_hue_path u_hue (
        .clk        (clk),
        .stage_load (stage_load[2:0]),
        .hue_deg    (hsv.hue_deg),
        .sector     (sector),
        .remainder  (remainder)
    );

    // Channel values and ordering.
    hsv2rgb_chan_path #(
        .FRAC_BITS  (FRAC_BITS),
        .STAGES     (STAGES)
    ) u_chan (
        .clk        (clk),
        .stage_load (stage_load),
        .saturation (hsv.saturation),
        .brightness (hsv.brightness),
        .sector     (sector),
        .remainder  (remainder),
        .rgb        (rgb)
    );

endmodule

### src/hsv2rgb_pipe_ctrl.sv
// Valid bits and per-stage load enables of the converter pipeline.
// Depends on hsv2rgb_pkg for the default stage count.
module hsv2rgb_pipe_ctrl #(
    parameter int STAGES = hsv2rgb_pkg::PIPE_STAGES
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [STAGES-1:0] stage_load
);

    logic [STAGES-1:0] valid_reg;
    logic [STAGES-1:0] valid_next;
    logic [STAGES:0]   ready;

    // A stage can load when it is empty or its contents move on this cycle.
    assign ready[STAGES] = !out_stall;

    for (genvar k = 0; k < STAGES; k++)
    begin : g_stage
        assign ready[k] = !valid_reg[k] || ready[k+1];
        if (k == 0)
        begin : g_first
            assign valid_next[k] = ready[k] ? in_valid : valid_reg[k];
        end
        else
        begin : g_rest
            assign valid_next[k] = ready[k] ? valid_reg[k-1] : valid_reg[k];
        end
    end

    // Valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign stage_load = ready[STAGES-1:0];
    assign in_stall   = !ready[0];
    assign out_valid  = valid_reg[STAGES-1];

endmodule

### src/hsv2rgb_hue_path.sv
// Hue reduction: wraps the signed hue into 0..359 and splits it into a
// sector and a remainder over three stages. Depends on hsv2rgb_pkg.
module hsv2rgb_hue_path (
    input  logic                 clk,
    input  logic [2:0]           stage_load,
    input  logic signed [15:0]   hue_deg,
    output hsv2rgb_pkg::sector_t sector,
    output logic [5:0]           remainder
);

    localparam int QW = hsv2rgb_pkg::HUE_QUOT_W;
    localparam int PW = 17 + 14;

    logic [16:0]           u_reg;
    logic [QW-1:0]         q_reg;
    logic [8:0]            h_reg;
    hsv2rgb_pkg::sector_t  sec_reg;
    logic [5:0]            rem_reg;

    logic [16:0]           biased;
    logic [16:0]           u_next;
    logic [PW-1:0]         recip_prod;
    logic [QW-1:0]         q_next;
    logic [16:0]           diff;
    logic [9:0]            h_wide;
    logic [8:0]            h_next;
    logic [2:0]            sec_cnt;
    logic [8:0]            sec_base;
    logic [8:0]            rem_wide;

    // Stage one: bias the hue positive and estimate the quotient by 360.
    always_comb
    begin
        biased     = 17'(hue_deg) + 17'(hsv2rgb_pkg::HUE_BIAS);
        u_next     = biased;
        recip_prod = PW'(u_next) * PW'(hsv2rgb_pkg::HUE_RECIP);
        q_next     = recip_prod[hsv2rgb_pkg::HUE_RECIP_SHIFT +: QW];
    end

    // Stage two: remainder by 360, corrected once when the quotient fell short.
    always_comb
    begin
        diff   = u_reg - 17'(q_reg) * 17'(hsv2rgb_pkg::HUE_FULL);
        h_wide = diff[9:0];
        if (h_wide >= 10'(hsv2rgb_pkg::HUE_FULL))
        begin
            h_next = 9'(h_wide - 10'(hsv2rgb_pkg::HUE_FULL));
        end
        else
        begin
            h_next = h_wide[8:0];
        end
    end

    // Stage three: the sector counts the sector boundaries at or below the hue.
    always_comb
    begin
        sec_cnt = '0;
        for (int k = 1; k < 6; k++)
        begin
            if (h_reg >= 9'(k * hsv2rgb_pkg::HUE_SECTOR))
            begin
                sec_cnt = sec_cnt + 3'd1;
            end
        end
        sec_base = 9'(sec_cnt) * 9'(hsv2rgb_pkg::HUE_SECTOR);
        rem_wide = h_reg - sec_base;
    end

    always_ff @(posedge clk)
    begin
        if (stage_load[0])
        begin
            u_reg <= u_next;
            q_reg <= q_next;
        end
        if (stage_load[1])
        begin
            h_reg <= h_next;
        end
        if (stage_load[2])
        begin
            sec_reg <= hsv2rgb_pkg::sector_t'(sec_cnt);
            rem_reg <= rem_wide[5:0];
        end
    end

    assign sector    = sec_reg;
    assign remainder = rem_reg;

endmodule

### src/hsv2rgb_chan_path.sv
// Channel arithmetic: clamps saturation and value, forms v, p, q and t
// scaled to 0..255 and orders them by sector. Depends on hsv2rgb_pkg.
module hsv2rgb_chan_path #(
    parameter int FRAC_BITS = hsv2rgb_pkg::FRAC_BITS_DEF,
    parameter int STAGES    = hsv2rgb_pkg::PIPE_STAGES
) (
    input  logic                   clk,
    input  logic [STAGES-1:0]      stage_load,
    input  logic signed [15:0]     saturation,
    input  logic signed [15:0]     brightness,
    input  hsv2rgb_pkg::sector_t   sector,
    input  logic [5:0]             remainder,
    output hsv2rgb_pkg::rgb_word_t rgb
);

    localparam int FB    = FRAC_BITS;
    localparam int SV_W  = FB + 1;
    localparam int PS_W  = 2 * FB + 1;
    localparam int SR_W  = FB + 6;
    localparam int M_W   = 2 * FB + 6;
    localparam int Y_W   = hsv2rgb_pkg::SCALED_W;
    localparam int D_W   = Y_W + hsv2rgb_pkg::DIV60_W;
    localparam int ONE   = 1 << FB;
    localparam int SIXTY_ONE = hsv2rgb_pkg::HUE_SECTOR << FB;
    localparam logic signed [15:0] ONE_S = 16'(ONE);

    // Stage registers, numbered by stage.
    logic [SV_W-1:0]        s0_reg, v0_reg;
    logic [PS_W-1:0]        ps1_reg;
    logic [SV_W-1:0]        s1_reg, v1_reg;
    logic [7:0]             cv2_reg, cp2_reg;
    logic [SV_W-1:0]        s2_reg, v2_reg;
    logic [SR_W-1:0]        sr3_reg, st3_reg;
    logic [SV_W-1:0]        v3_reg;
    logic [7:0]             cv3_reg, cp3_reg;
    hsv2rgb_pkg::sector_t   sec3_reg;
    logic [M_W-1:0]         mq4_reg, mt4_reg;
    logic [7:0]             cv4_reg, cp4_reg;
    hsv2rgb_pkg::sector_t   sec4_reg;
    logic [Y_W-1:0]         yq5_reg, yt5_reg;
    logic [7:0]             cv5_reg, cp5_reg;
    hsv2rgb_pkg::sector_t   sec5_reg;
    hsv2rgb_pkg::rgb_word_t rgb_reg;

    logic [SV_W-1:0]        s0_next, v0_next;
    logic [SV_W-1:0]        one_minus_s;
    logic [PS_W-1:0]        ps1_next;
    logic [SV_W+7:0]        v_scaled;
    logic [PS_W+7:0]        p_scaled;
    logic [5:0]             rem_inv;
    logic [SR_W-1:0]        sr3_next, st3_next;
    logic [SR_W-1:0]        aq, at;
    logic [M_W-1:0]         mq4_next, mt4_next;
    logic [M_W+7:0]         q_scaled, t_scaled;
    logic [D_W-1:0]         q_div, t_div;
    logic [7:0]             cq, ct;
    hsv2rgb_pkg::rgb_word_t rgb_next;

    // Stage one: clamp saturation and value to 0..1.
    always_comb
    begin
        if (saturation < 16'sd0)
        begin
            s0_next = '0;
        end
        else if (saturation > ONE_S)
        begin
            s0_next = SV_W'(ONE);
        end
        else
        begin
            s0_next = saturation[SV_W-1:0];
        end

        if (brightness < 16'sd0)
        begin
            v0_next = '0;
        end
        else if (brightness > ONE_S)
        begin
            v0_next = SV_W'(ONE);
        end
        else
        begin
            v0_next = brightness[SV_W-1:0];
        end
    end

    // Stage two: p before scaling, v(1 - s).
    always_comb
    begin
        one_minus_s = SV_W'(ONE) - s0_reg;
        ps1_next    = PS_W'(v0_reg) * PS_W'(one_minus_s);
    end

    // Stage three: v and p times 255, truncated back to eight bits.
    always_comb
    begin
        v_scaled = {v1_reg, 8'b0} - (SV_W + 8)'(v1_reg);
        p_scaled = {ps1_reg, 8'b0} - (PS_W + 8)'(ps1_reg);
    end

    // Stage four: s times the remainder and s times its complement in the sector.
    always_comb
    begin
        rem_inv  = 6'(hsv2rgb_pkg::HUE_SECTOR) - remainder;
        sr3_next = SR_W'(s2_reg) * SR_W'(remainder);
        st3_next = SR_W'(s2_reg) * SR_W'(rem_inv);
    end

    // Stage five: q and t over the common denominator 60 * one * one.
    always_comb
    begin
        aq       = SR_W'(SIXTY_ONE) - sr3_reg;
        at       = SR_W'(SIXTY_ONE) - st3_reg;
        mq4_next = M_W'(v3_reg) * M_W'(aq);
        mt4_next = M_W'(v3_reg) * M_W'(at);
    end

    // Stage six: times 255, with the one * one part of the denominator shifted out.
    always_comb
    begin
        q_scaled = {mq4_reg, 8'b0} - (M_W + 8)'(mq4_reg);
        t_scaled = {mt4_reg, 8'b0} - (M_W + 8)'(mt4_reg);
    end

    // Stage seven: divide by 60 through the reciprocal, then order the channels.
    always_comb
    begin
        q_div = D_W'(yq5_reg) * D_W'(hsv2rgb_pkg::DIV60_RECIP);
        t_div = D_W'(yt5_reg) * D_W'(hsv2rgb_pkg::DIV60_RECIP);
        cq    = q_div[hsv2rgb_pkg::DIV60_SHIFT +: 8];
        ct    = t_div[hsv2rgb_pkg::DIV60_SHIFT +: 8];

        unique case (sec5_reg)
            hsv2rgb_pkg::SECT_YELLOW:
            begin
                rgb_next.red = cq;      rgb_next.green = cv5_reg; rgb_next.blue = cp5_reg;
            end
            hsv2rgb_pkg::SECT_GREEN:
            begin
                rgb_next.red = cp5_reg; rgb_next.green = cv5_reg; rgb_next.blue = ct;
            end
            hsv2rgb_pkg::SECT_CYAN:
            begin
                rgb_next.red = cp5_reg; rgb_next.green = cq;      rgb_next.blue = cv5_reg;
            end
            hsv2rgb_pkg::SECT_BLUE:
            begin
                rgb_next.red = ct;      rgb_next.green = cp5_reg; rgb_next.blue = cv5_reg;
            end
            hsv2rgb_pkg::SECT_MAGENTA:
            begin
                rgb_next.red = cv5_reg; rgb_next.green = cp5_reg; rgb_next.blue = cq;
            end
            default:
            begin
                rgb_next.red = cv5_reg; rgb_next.green = ct;      rgb_next.blue = cp5_reg;
            end
        endcase
    end

    // Payload registers, each loaded when its stage takes a new word.
    always_ff @(posedge clk)
    begin
        if (stage_load[0])
        begin
            s0_reg <= s0_next;
            v0_reg <= v0_next;
        end
        if (stage_load[1])
        begin
            ps1_reg <= ps1_next;
            s1_reg  <= s0_reg;
            v1_reg  <= v0_reg;
        end
        if (stage_load[2])
        begin
            cv2_reg <= v_scaled[FB +: 8];
            cp2_reg <= p_scaled[2 * FB +: 8];
            s2_reg  <= s1_reg;
            v2_reg  <= v1_reg;
        end
        if (stage_load[3])
        begin
            sr3_reg  <= sr3_next;
            st3_reg  <= st3_next;
            v3_reg   <= v2_reg;
            cv3_reg  <= cv2_reg;
            cp3_reg  <= cp2_reg;
            sec3_reg <= sector;
        end
        if (stage_load[4])
        begin
            mq4_reg  <= mq4_next;
            mt4_reg  <= mt4_next;
            cv4_reg  <= cv3_reg;
            cp4_reg  <= cp3_reg;
            sec4_reg <= sec3_reg;
        end
        if (stage_load[5])
        begin
            yq5_reg  <= q_scaled[2 * FB +: Y_W];
            yt5_reg  <= t_scaled[2 * FB +: Y_W];
            cv5_reg  <= cv4_reg;
            cp5_reg  <= cp4_reg;
            sec5_reg <= sec4_reg;
        end
        if (stage_load[6])
        begin
            rgb_reg <= rgb_next;
        end
    end

    assign rgb = rgb_reg;

endmodule

### src/hsv2rgb_checker.sv
// Port-level checks of the converter, bound to the top level.
// Depends on hsv2rgb_pkg and hsv_to_rgb_converter_top.
module hsv2rgb_checker (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   hsv_valid,
    input logic                   hsv_stall,
    input logic                   rgb_valid,
    input logic                   rgb_stall,
    input hsv2rgb_pkg::rgb_word_t rgb
);

    // A waiting result word stays put until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        rgb_valid && rgb_stall |=> rgb_valid && $stable(rgb))
        else $error("result word changed while stalled");

    // With the output free every stage can advance, so the input never stalls.
    assert property (@(posedge clk) disable iff (!rst_n)
        !rgb_stall |-> !hsv_stall)
        else $error("input stalled while the output was free");

    // A word taken while the output then keeps running free comes out as a result.
    assert property (@(posedge clk) disable iff (!rst_n)
        (hsv_valid && !hsv_stall && !rgb_stall) ##1 !rgb_stall ##1 !rgb_stall
        ##1 !rgb_stall ##1 !rgb_stall ##1 !rgb_stall ##1 !rgb_stall |=> rgb_valid)
        else $error("result word missing after the pipeline latency");

endmodule

bind hsv_to_rgb_converter_top hsv2rgb_checker u_checker (.*);
